// File: hdl/iole_pkg.sv
package iole_pkg;

    localparam int MODE_W      = 3;
    localparam int POS_W       = 4;
    localparam int VAL_W       = 32;
    localparam int STATUS_W    = 3;
    localparam int IDX_OUT_W   = 4;
    localparam int COUNT_OUT_W = 5;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QFILL_W     = 2;

    localparam logic [MODE_W-1:0] MODE_APPEND   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LOCATE   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MAX      = 3'd4;
    localparam logic [MODE_W-1:0] MODE_READ_FWD = 3'd5;
    localparam logic [MODE_W-1:0] MODE_READ_REV = 3'd6;

    typedef enum logic [2:0] {
        OP_APPEND   = 3'd0,
        OP_INSERT   = 3'd1,
        OP_DELETE   = 3'd2,
        OP_LOCATE   = 3'd3,
        OP_MAX      = 3'd4,
        OP_READ_FWD = 3'd5,
        OP_READ_REV = 3'd6,
        OP_NOP      = 3'd7
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_INDEX = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    typedef struct packed {
        op_t              op;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] value;
    } cmd_t;

endpackage

// File: hdl/iole_front.sv
module iole_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [iole_pkg::MODE_W-1:0] mode,
    input  logic [iole_pkg::POS_W-1:0]  position,
    input  logic [iole_pkg::VAL_W-1:0]  value,
    output logic                        cmd_valid,
    input  logic                        cmd_ready,
    output iole_pkg::cmd_t              cmd
);

    iole_pkg::cmd_t                     cmd_dec;
    iole_pkg::cmd_t                     q_reg [iole_pkg::QUEUE_DEPTH];
    logic [iole_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [iole_pkg::QPTR_W-1:0]        wr_ptr_next;
    logic [iole_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [iole_pkg::QPTR_W-1:0]        rd_ptr_next;
    logic [iole_pkg::QFILL_W-1:0]       fill_reg;
    logic [iole_pkg::QFILL_W-1:0]       fill_next;
    logic                               push;
    logic                               pop;

    // classify the command
    always_comb
    begin
        cmd_dec.position = position;
        cmd_dec.value    = value;
        unique case (mode)
            iole_pkg::MODE_APPEND:   cmd_dec.op = iole_pkg::OP_APPEND;
            iole_pkg::MODE_INSERT:   cmd_dec.op = iole_pkg::OP_INSERT;
            iole_pkg::MODE_DELETE:   cmd_dec.op = iole_pkg::OP_DELETE;
            iole_pkg::MODE_LOCATE:   cmd_dec.op = iole_pkg::OP_LOCATE;
            iole_pkg::MODE_MAX:      cmd_dec.op = iole_pkg::OP_MAX;
            iole_pkg::MODE_READ_FWD: cmd_dec.op = iole_pkg::OP_READ_FWD;
            iole_pkg::MODE_READ_REV: cmd_dec.op = iole_pkg::OP_READ_REV;
            default:                 cmd_dec.op = iole_pkg::OP_NOP;
        endcase
    end

    assign in_ready  = (fill_reg != iole_pkg::QFILL_W'(iole_pkg::QUEUE_DEPTH));
    assign cmd_valid = (fill_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_dec;
        end
    end

endmodule

// File: hdl/iole_back.sv
module iole_back
#(
    parameter int CAPACITY = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_ready,
    input  iole_pkg::cmd_t                   cmd,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [iole_pkg::STATUS_W-1:0]    status,
    output logic [iole_pkg::IDX_OUT_W-1:0]   found_index,
    output logic [iole_pkg::VAL_W-1:0]       element_out,
    output logic [iole_pkg::COUNT_OUT_W-1:0] element_count,
    output logic                             last
);

    localparam int IdxW = $clog2(CAPACITY);
    localparam int CntW = $clog2(CAPACITY + 1);
    localparam int CmpW = CntW + iole_pkg::POS_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WALK = 4'b0010,
        S_PUT  = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [CntW-1:0]                 count_reg;
    logic [CntW-1:0]                 count_next;
    iole_pkg::op_t                   op_reg;
    iole_pkg::op_t                   op_next;
    logic [IdxW-1:0]                 pos_reg;
    logic [IdxW-1:0]                 pos_next;
    logic [iole_pkg::VAL_W-1:0]      val_reg;
    logic [iole_pkg::VAL_W-1:0]      val_next;
    logic [IdxW-1:0]                 walk_idx_reg;
    logic [IdxW-1:0]                 walk_idx_next;
    logic [CntW-1:0]                 walk_rem_reg;
    logic [CntW-1:0]                 walk_rem_next;
    logic                            pend_reg;
    logic                            pend_next;
    logic [IdxW-1:0]                 pend_idx_reg;
    logic [IdxW-1:0]                 pend_idx_next;
    logic [IdxW-1:0]                 best_idx_reg;
    logic [IdxW-1:0]                 best_idx_next;
    logic [iole_pkg::VAL_W-1:0]      best_val_reg;
    logic [iole_pkg::VAL_W-1:0]      best_val_next;
    iole_pkg::status_t               res_status_reg;
    iole_pkg::status_t               res_status_next;
    logic [IdxW-1:0]                 res_idx_reg;
    logic [IdxW-1:0]                 res_idx_next;
    logic [iole_pkg::VAL_W-1:0]      res_elem_reg;
    logic [iole_pkg::VAL_W-1:0]      res_elem_next;

    logic [iole_pkg::VAL_W-1:0]      mem_array [CAPACITY];
    logic [iole_pkg::VAL_W-1:0]      rd_data_reg;
    logic                            mem_we;
    logic [IdxW-1:0]                 mem_waddr;
    logic [iole_pkg::VAL_W-1:0]      mem_wdata;
    logic                            mem_re;

    logic                            out_valid_reg;
    logic                            out_valid_next;
    iole_pkg::status_t               out_status_reg;
    logic [iole_pkg::IDX_OUT_W-1:0]  out_idx_reg;
    logic [iole_pkg::VAL_W-1:0]      out_elem_reg;
    logic [iole_pkg::COUNT_OUT_W-1:0] out_count_reg;
    logic                            out_last_reg;
    logic                            out_load;
    iole_pkg::status_t               out_status_d;
    logic [IdxW-1:0]                 out_idx_src;
    logic [IdxW+iole_pkg::IDX_OUT_W-1:0] out_idx_wide;
    logic [CntW+iole_pkg::COUNT_OUT_W-1:0] out_cnt_wide;
    logic [iole_pkg::VAL_W-1:0]      out_elem_d;
    logic                            out_last_d;

    logic [CmpW-1:0]                 pos_wide;
    logic [CmpW-1:0]                 cnt_wide;
    logic [CntW-1:0]                 cnt_m1;
    logic                            list_full;
    logic                            is_read;
    logic                            descend;
    logic                            slot_free;
    logic                            stall;
    logic                            hit;

    assign pos_wide  = CmpW'(cmd.position);
    assign cnt_wide  = CmpW'(count_reg);
    assign cnt_m1    = count_reg - 1'b1;
    assign list_full = (count_reg >= CntW'(CAPACITY));
    assign is_read   = (op_reg == iole_pkg::OP_READ_FWD) || (op_reg == iole_pkg::OP_READ_REV);
    assign descend   = (op_reg == iole_pkg::OP_INSERT) || (op_reg == iole_pkg::OP_READ_REV);
    assign slot_free = !out_valid_reg || out_ready;
    assign stall     = pend_reg && is_read && !slot_free;
    assign cmd_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        op_next         = op_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        walk_idx_next   = walk_idx_reg;
        walk_rem_next   = walk_rem_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        best_idx_next   = best_idx_reg;
        best_val_next   = best_val_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_elem_next   = res_elem_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        out_load        = 1'b0;
        out_status_d    = res_status_reg;
        out_idx_src     = res_idx_reg;
        out_elem_d      = res_elem_reg;
        out_last_d      = 1'b1;
        hit             = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next         = cmd.op;
                    pos_next        = pos_wide[IdxW-1:0];
                    val_next        = cmd.value;
                    pend_next       = 1'b0;
                    res_status_next = iole_pkg::ST_OK;
                    res_idx_next    = '0;
                    res_elem_next   = '0;
                    walk_idx_next   = '0;
                    walk_rem_next   = count_reg;
                    state_next      = S_EMIT;
                    unique case (cmd.op) inside
                        iole_pkg::OP_APPEND:
                        begin
                            if (list_full)
                            begin
                                res_status_next = iole_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[IdxW-1:0];
                                mem_wdata  = cmd.value;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        iole_pkg::OP_INSERT:
                        begin
                            if (pos_wide >= cnt_wide)
                            begin
                                res_status_next = iole_pkg::ST_BAD_INDEX;
                            end
                            else if (list_full)
                            begin
                                res_status_next = iole_pkg::ST_FULL;
                            end
                            else
                            begin
                                // move entries pos..count-1 up by one, top first
                                walk_idx_next = cnt_m1[IdxW-1:0];
                                walk_rem_next = count_reg - pos_wide[CntW-1:0];
                                state_next    = S_WALK;
                            end
                        end
                        iole_pkg::OP_DELETE:
                        begin
                            if (pos_wide >= cnt_wide)
                            begin
                                res_status_next = iole_pkg::ST_BAD_INDEX;
                            end
                            else
                            begin
                                walk_idx_next = pos_wide[IdxW-1:0] + 1'b1;
                                walk_rem_next = cnt_m1 - pos_wide[CntW-1:0];
                                state_next    = S_WALK;
                            end
                        end
                        iole_pkg::OP_LOCATE:
                        begin
                            state_next = S_WALK;
                        end
                        iole_pkg::OP_MAX, iole_pkg::OP_READ_FWD:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = iole_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_WALK;
                            end
                        end
                        iole_pkg::OP_READ_REV:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = iole_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                walk_idx_next = cnt_m1[IdxW-1:0];
                                state_next    = S_WALK;
                            end
                        end
                        default:
                        begin
                            res_status_next = iole_pkg::ST_OK;
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                if (!stall)
                begin
                    // retire the pending element held in rd_data_reg
                    if (pend_reg)
                    begin
                        case (op_reg) inside
                            iole_pkg::OP_LOCATE:
                            begin
                                hit = (rd_data_reg == val_reg);
                            end
                            iole_pkg::OP_MAX:
                            begin
                                if ((pend_idx_reg == '0) ||
                                    ($signed(rd_data_reg) > $signed(best_val_reg)))
                                begin
                                    best_idx_next = pend_idx_reg;
                                    best_val_next = rd_data_reg;
                                end
                            end
                            iole_pkg::OP_INSERT:
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = pend_idx_reg + 1'b1;
                                mem_wdata = rd_data_reg;
                            end
                            iole_pkg::OP_DELETE:
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = pend_idx_reg - 1'b1;
                                mem_wdata = rd_data_reg;
                            end
                            iole_pkg::OP_READ_FWD, iole_pkg::OP_READ_REV:
                            begin
                                out_load     = 1'b1;
                                out_status_d = iole_pkg::ST_OK;
                                out_idx_src  = pend_idx_reg;
                                out_elem_d   = rd_data_reg;
                                out_last_d   = (walk_rem_reg == '0);
                            end
                            default:
                            begin
                                hit = 1'b0;
                            end
                        endcase
                    end

                    if (hit)
                    begin
                        // drop the rest of the scan
                        res_status_next = iole_pkg::ST_OK;
                        res_idx_next    = pend_idx_reg;
                        pend_next       = 1'b0;
                        state_next      = S_EMIT;
                    end
                    else if (walk_rem_reg != '0)
                    begin
                        mem_re        = 1'b1;
                        pend_next     = 1'b1;
                        pend_idx_next = walk_idx_reg;
                        walk_rem_next = walk_rem_reg - 1'b1;
                        walk_idx_next = descend ? walk_idx_reg - 1'b1 : walk_idx_reg + 1'b1;
                    end
                    else
                    begin
                        pend_next = 1'b0;
                        case (op_reg)
                            iole_pkg::OP_INSERT:
                            begin
                                state_next = S_PUT;
                            end
                            iole_pkg::OP_DELETE:
                            begin
                                count_next      = cnt_m1;
                                res_status_next = iole_pkg::ST_OK;
                                state_next      = S_EMIT;
                            end
                            iole_pkg::OP_LOCATE:
                            begin
                                res_status_next = iole_pkg::ST_NOT_FOUND;
                                res_idx_next    = '0;
                                state_next      = S_EMIT;
                            end
                            iole_pkg::OP_MAX:
                            begin
                                res_status_next = iole_pkg::ST_OK;
                                res_idx_next    = best_idx_next;
                                res_elem_next   = best_val_next;
                                state_next      = S_EMIT;
                            end
                            default:
                            begin
                                state_next = S_IDLE;
                            end
                        endcase
                    end
                end
            end

            S_PUT:
            begin
                mem_we          = 1'b1;
                mem_waddr       = pos_reg;
                mem_wdata       = val_reg;
                count_next      = count_reg + 1'b1;
                res_status_next = iole_pkg::ST_OK;
                state_next      = S_EMIT;
            end

            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_idx_wide   = (IdxW + iole_pkg::IDX_OUT_W)'(out_idx_src);
    assign out_cnt_wide   = (CntW + iole_pkg::COUNT_OUT_W)'(count_reg);
    assign out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        walk_idx_reg   <= walk_idx_next;
        walk_rem_reg   <= walk_rem_next;
        pend_idx_reg   <= pend_idx_next;
        best_idx_reg   <= best_idx_next;
        best_val_reg   <= best_val_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        res_elem_reg   <= res_elem_next;
        if (out_load)
        begin
            out_status_reg <= out_status_d;
            out_idx_reg    <= out_idx_wide[iole_pkg::IDX_OUT_W-1:0];
            out_elem_reg   <= out_elem_d;
            out_count_reg  <= out_cnt_wide[iole_pkg::COUNT_OUT_W-1:0];
            out_last_reg   <= out_last_d;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_array[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem_array[walk_idx_reg];
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign found_index   = out_idx_reg;
    assign element_out   = out_elem_reg;
    assign element_count = out_count_reg;
    assign last          = out_last_reg;

endmodule

// File: hdl/indexed_ordered_list_engine.sv
// Channel   Handshake              Payload
// in        in_valid / in_ready    mode, position, value
// out       out_valid / out_ready  status, found_index, element_out, element_count, last
//
// A two-entry command queue sits in front of the list sequencer, so input keeps
// flowing while results wait. Append, no-op, reject and empty-list cases go from idle
// straight to the result; insert, delete, locate and max walk the list memory, reading
// it once per cycle, and insert then writes the new entry. Read-outs give one element
// per cycle while the output is not stalled. Reset clears the count and control state,
// not the list entries. A stalled output freezes the read-out walk in place.
module indexed_ordered_list_engine
#(
    parameter int CAPACITY = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [iole_pkg::MODE_W-1:0]      mode,
    input  logic [iole_pkg::POS_W-1:0]       position,
    input  logic [iole_pkg::VAL_W-1:0]       value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [iole_pkg::STATUS_W-1:0]    status,
    output logic [iole_pkg::IDX_OUT_W-1:0]   found_index,
    output logic [iole_pkg::VAL_W-1:0]       element_out,
    output logic [iole_pkg::COUNT_OUT_W-1:0] element_count,
    output logic                             last
);

    iole_pkg::cmd_t cmd;
    logic           cmd_valid;
    logic           cmd_ready;

    iole_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .position  (position),
        .value     (value),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    iole_back #(
        .CAPACITY (CAPACITY)
    ) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .found_index   (found_index),
        .element_out   (element_out),
        .element_count (element_count),
        .last          (last)
    );

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int CAP         = 16;
    localparam int TAIL_CYCLES = 40;
    localparam int ITEMS_PHASE = 120;

    typedef struct {
        logic [iole_pkg::MODE_W-1:0] mode;
        logic [iole_pkg::POS_W-1:0]  position;
        logic [iole_pkg::VAL_W-1:0]  value;
        bit                          drain;
        int unsigned                 src_idle;
        int unsigned                 sink_stall;
    } list_cmd_t;

    typedef struct {
        iole_pkg::status_t                status;
        logic [iole_pkg::IDX_OUT_W-1:0]   found_index;
        logic [iole_pkg::VAL_W-1:0]       element_out;
        logic [iole_pkg::COUNT_OUT_W-1:0] element_count;
        logic                             last;
    } list_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                             in_valid = 1'b0;
    logic                             in_ready;
    logic [iole_pkg::MODE_W-1:0]      mode = '0;
    logic [iole_pkg::POS_W-1:0]       position = '0;
    logic [iole_pkg::VAL_W-1:0]       value = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic [iole_pkg::STATUS_W-1:0]    status;
    logic [iole_pkg::IDX_OUT_W-1:0]   found_index;
    logic [iole_pkg::VAL_W-1:0]       element_out;
    logic [iole_pkg::COUNT_OUT_W-1:0] element_count;
    logic                             last;

    list_cmd_t    command_queue [$];
    list_result_t list_results_due [$];

    // predictor state
    logic [iole_pkg::VAL_W-1:0] model_list [CAP];
    int                         model_count = 0;

    // generator state
    int          gen_count = 0;
    int unsigned cur_src_idle = 0;
    int unsigned cur_sink_stall = 0;
    bit          next_drain = 1'b0;

    int unsigned sink_stall_pct = 0;
    bit          in_taken = 1'b0;
    int          mismatch_count = 0;

    int unsigned phase_src_idle  [4] = '{0, 73, 0, 13};
    int unsigned phase_sink_stall[4] = '{0, 0, 73, 13};

    logic [iole_pkg::VAL_W-1:0] value_pool [8] = '{
        32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0001_0000,
        32'hFFFF_0000, 32'h0000_8000, 32'hFFFF_FFFF, 32'h1234_5678
    };

    indexed_ordered_list_engine #(
        .CAPACITY(CAP)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .position     (position),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .found_index  (found_index),
        .element_out  (element_out),
        .element_count(element_count),
        .last         (last)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic void push_result(iole_pkg::status_t st, int idx,
                                        logic [iole_pkg::VAL_W-1:0] elem, logic fin);
        list_result_t r;
        r.status        = st;
        r.found_index   = idx[iole_pkg::IDX_OUT_W-1:0];
        r.element_out   = elem;
        r.element_count = model_count[iole_pkg::COUNT_OUT_W-1:0];
        r.last          = fin;
        list_results_due.push_back(r);
    endfunction

    function automatic void apply_list_command(logic [iole_pkg::MODE_W-1:0] cmd_mode,
                                               logic [iole_pkg::POS_W-1:0] cmd_pos,
                                               logic [iole_pkg::VAL_W-1:0] cmd_val);
        iole_pkg::op_t op;
        int            pos;
        int            best;
        bit            hit;
        op  = iole_pkg::op_t'(cmd_mode);
        pos = int'(cmd_pos);
        case (op) inside
            iole_pkg::OP_APPEND:
            begin
                if (model_count >= CAP)
                    push_result(iole_pkg::ST_FULL, 0, '0, 1'b1);
                else
                begin
                    model_list[model_count] = cmd_val;
                    model_count++;
                    push_result(iole_pkg::ST_OK, 0, '0, 1'b1);
                end
            end
            iole_pkg::OP_INSERT:
            begin
                if (pos >= model_count)
                    push_result(iole_pkg::ST_BAD_INDEX, 0, '0, 1'b1);
                else if (model_count >= CAP)
                    push_result(iole_pkg::ST_FULL, 0, '0, 1'b1);
                else
                begin
                    for (int i = model_count; i > pos; i--)
                        model_list[i] = model_list[i-1];
                    model_list[pos] = cmd_val;
                    model_count++;
                    push_result(iole_pkg::ST_OK, 0, '0, 1'b1);
                end
            end
            iole_pkg::OP_DELETE:
            begin
                if (pos >= model_count)
                    push_result(iole_pkg::ST_BAD_INDEX, 0, '0, 1'b1);
                else
                begin
                    for (int i = pos; i + 1 < model_count; i++)
                        model_list[i] = model_list[i+1];
                    model_count--;
                    push_result(iole_pkg::ST_OK, 0, '0, 1'b1);
                end
            end
            iole_pkg::OP_LOCATE:
            begin
                hit = 1'b0;
                for (int i = 0; i < model_count && !hit; i++)
                begin
                    if (model_list[i] == cmd_val)
                    begin
                        hit = 1'b1;
                        push_result(iole_pkg::ST_OK, i, '0, 1'b1);
                    end
                end
                if (!hit)
                    push_result(iole_pkg::ST_NOT_FOUND, 0, '0, 1'b1);
            end
            iole_pkg::OP_MAX:
            begin
                if (model_count == 0)
                    push_result(iole_pkg::ST_EMPTY, 0, '0, 1'b1);
                else
                begin
                    // strict compare keeps the lowest index among equal maxima
                    best = 0;
                    for (int i = 1; i < model_count; i++)
                        if ($signed(model_list[i]) > $signed(model_list[best]))
                            best = i;
                    push_result(iole_pkg::ST_OK, best, model_list[best], 1'b1);
                end
            end
            iole_pkg::OP_READ_FWD, iole_pkg::OP_READ_REV:
            begin
                if (model_count == 0)
                    push_result(iole_pkg::ST_EMPTY, 0, '0, 1'b1);
                else
                    for (int i = 0; i < model_count; i++)
                    begin
                        best = (op == iole_pkg::OP_READ_FWD) ? i : model_count - 1 - i;
                        push_result(iole_pkg::ST_OK, best, model_list[best],
                                    i + 1 == model_count);
                    end
            end
            default:
                push_result(iole_pkg::ST_OK, 0, '0, 1'b1);
        endcase
    endfunction

    function automatic void add_cmd(logic [iole_pkg::MODE_W-1:0] m, int p,
                                    logic [iole_pkg::VAL_W-1:0] v);
        list_cmd_t c;
        c.mode       = m;
        c.position   = p[iole_pkg::POS_W-1:0];
        c.value      = v;
        c.drain      = next_drain;
        c.src_idle   = cur_src_idle;
        c.sink_stall = cur_sink_stall;
        next_drain   = 1'b0;
        command_queue.push_back(c);
        // track the fill level so the random part can steer it
        if (m == iole_pkg::MODE_APPEND && gen_count < CAP)
            gen_count++;
        else if (m == iole_pkg::MODE_INSERT && p < gen_count && gen_count < CAP)
            gen_count++;
        else if (m == iole_pkg::MODE_DELETE && p < gen_count)
            gen_count--;
    endfunction

    function automatic logic [iole_pkg::VAL_W-1:0] pick_value();
        if ($urandom_range(1) == 0)
            return value_pool[$urandom_range(7)];
        return $urandom;
    endfunction

    function automatic int pick_position();
        if (gen_count > 0 && $urandom_range(99) < 80)
            return $urandom_range(gen_count - 1);
        return $urandom_range(15);
    endfunction

    // driver: present transactions at the falling edge
    always @(negedge clk)
    begin
        list_cmd_t nxt;
        logic      show;
        show = in_valid && !in_taken;
        if (rst_n && !show && command_queue.size() > 0)
        begin
            if (command_queue[0].drain && list_results_due.size() > 0)
                show = 1'b0;
            else if ($urandom_range(99) < command_queue[0].src_idle)
                show = 1'b0;
            else
            begin
                nxt            = command_queue.pop_front();
                mode           <= nxt.mode;
                position       <= nxt.position;
                value          <= nxt.value;
                sink_stall_pct = nxt.sink_stall;
                show           = 1'b1;
            end
        end
        in_valid  <= show;
        out_ready <= rst_n && ($urandom_range(99) >= sink_stall_pct);
    end

    // monitor: predict on accepted commands, check accepted results
    always @(posedge clk)
    begin
        list_result_t exp_r;
        in_taken = 1'b0;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                apply_list_command(mode, position, value);
                in_taken = 1'b1;
            end
            if (out_valid && out_ready)
            begin
                if (list_results_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected status %0d idx %0d elem %h cnt %0d last %0b",
                                 $time, status, found_index, element_out, element_count,
                                 last);
                end
                else
                begin
                    exp_r = list_results_due.pop_front();
                    if (status !== exp_r.status || found_index !== exp_r.found_index ||
                        element_out !== exp_r.element_out ||
                        element_count !== exp_r.element_count || last !== exp_r.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("%0t: exp status %0d idx %0d elem %h cnt %0d last %0b",
                                     $time, exp_r.status, exp_r.found_index,
                                     exp_r.element_out, exp_r.element_count, exp_r.last);
                            $display("%0t: act status %0d idx %0d elem %h cnt %0d last %0b",
                                     $time, status, found_index, element_out,
                                     element_count, last);
                        end
                    end
                end
            end
        end
    end

    initial
    begin
        #1_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        int                          target;
        int                          r;
        logic [iole_pkg::MODE_W-1:0] op_code;

        target = 8;

        // empty list corner cases
        add_cmd(iole_pkg::MODE_READ_FWD, 0, '0);
        add_cmd(iole_pkg::MODE_READ_REV, 0, '0);
        add_cmd(iole_pkg::MODE_MAX, 0, '0);
        add_cmd(iole_pkg::MODE_LOCATE, 0, '0);
        add_cmd(iole_pkg::MODE_INSERT, 0, 32'h0001_0000);
        add_cmd(iole_pkg::MODE_DELETE, 0, '0);
        add_cmd(iole_pkg::MODE_W'(iole_pkg::OP_NOP), 0, '0);
        // extremes, duplicate maxima, boundary indexes
        add_cmd(iole_pkg::MODE_APPEND, 0, 32'h7FFF_FFFF);
        add_cmd(iole_pkg::MODE_APPEND, 0, 32'h8000_0000);
        add_cmd(iole_pkg::MODE_APPEND, 0, 32'h7FFF_FFFF);
        add_cmd(iole_pkg::MODE_INSERT, 0, 32'hFFFF_FFFF);
        add_cmd(iole_pkg::MODE_INSERT, 3, 32'h0000_0000);
        add_cmd(iole_pkg::MODE_INSERT, 5, 32'h1234_5678);
        add_cmd(iole_pkg::MODE_LOCATE, 0, 32'h7FFF_FFFF);
        add_cmd(iole_pkg::MODE_LOCATE, 0, 32'h1234_5678);
        add_cmd(iole_pkg::MODE_MAX, 0, '0);
        add_cmd(iole_pkg::MODE_READ_FWD, 0, '0);
        add_cmd(iole_pkg::MODE_READ_REV, 0, '0);
        add_cmd(iole_pkg::MODE_DELETE, 4, '0);
        add_cmd(iole_pkg::MODE_DELETE, 0, '0);
        add_cmd(iole_pkg::MODE_DELETE, 15, '0);
        add_cmd(iole_pkg::MODE_W'(iole_pkg::OP_NOP), 15, 32'hFFFF_FFFF);

        for (int ph = 0; ph < 4; ph++)
        begin
            cur_src_idle   = phase_src_idle[ph];
            cur_sink_stall = phase_sink_stall[ph];
            // hold the first transaction of each phase until the engine drains
            next_drain     = 1'b1;
            for (int n = 0; n < ITEMS_PHASE; n++)
            begin
                if (n % 20 == 0)
                    target = ($urandom_range(3) == 0) ? CAP : $urandom_range(CAP);
                r = $urandom_range(99);
                if (r < 10)
                    op_code = iole_pkg::MODE_W'($urandom_range(7));
                else if (r < 50 && gen_count < target)
                    op_code = $urandom_range(1) ? iole_pkg::MODE_APPEND
                                                : iole_pkg::MODE_INSERT;
                else if (r < 50 && gen_count > target)
                    op_code = iole_pkg::MODE_DELETE;
                else
                    op_code = iole_pkg::MODE_W'($urandom_range(6));
                add_cmd(op_code, pick_position(), pick_value());
            end
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (command_queue.size() != 0 || in_valid || list_results_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && list_results_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
